// ----- rtl/core/lfbp_pkg.sv -----
// lfbp_pkg: shared types and constants for the length framed byte parser
// no dependencies; imported by length_framed_byte_parser

package lfbp_pkg;

   localparam int unsigned MAX_PAYLOAD_DEF = 32;
   localparam int unsigned BYTE_W          = 8;
   localparam int unsigned STATUS_W        = 4;
   localparam int unsigned CSR_ADDR_W      = 1;
   localparam int unsigned RSP_DATA_W      = 16;

   localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'hAA;
   localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'h55;

   // register indexes on the csr port
   localparam logic [CSR_ADDR_W-1:0] CSR_START_MARKER = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_END_MARKER   = 1'b1;

   // sticky status bit positions
   localparam int unsigned ST_START_SEEN   = 0;
   localparam int unsigned ST_LENGTH_OK    = 1;
   localparam int unsigned ST_PAYLOAD_DONE = 2;
   localparam int unsigned ST_END_SEEN     = 3;

   typedef enum logic [3:0] {
      PH_WAIT_START = 4'b0001,
      PH_WAIT_LEN   = 4'b0010,
      PH_PAYLOAD    = 4'b0100,
      PH_WAIT_END   = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status_flags;
      logic                length_rejected;
      logic                frame_done;
      logic                payload_last;
      logic                payload_valid;
      logic [BYTE_W-1:0]   payload_byte;
   } result_type;

endpackage

// ----- rtl/core/length_framed_byte_parser.sv -----
// length_framed_byte_parser: start / length / payload / end frame parser, one byte per item
// depends on lfbp_pkg (types, constants)
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+------------------------------------------
//  req      | in  | req_tvalid/req_tready  | req_tdata[7:0] rx_byte
//  rsp      | out | rsp_tvalid/rsp_tready  | tdata byte + flags, tuser valid, tlast last
//  csr      | in  | csr_we (no wait)       | csr_addr register index, csr_wdata value
//
// one item per cycle sustained while rsp_tready stays high; each item leaves one result in the cycle after acceptance
// parse state and the result register update together on the accepting edge
// the result register frees in the cycle it is taken, so req_tready follows rsp_tready
// synchronous active high reset clears phase, counters, sticky bits, markers to defaults
// a stalled rsp side holds its result and stalls req after one pending item

module length_framed_byte_parser #(
   parameter int unsigned MAX_PAYLOAD = lfbp_pkg::MAX_PAYLOAD_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: [7:0] rx_byte
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [lfbp_pkg::BYTE_W-1:0]         req_tdata,
   // rsp_tdata: [7:0] payload_byte, [8] frame_done, [9] length_rejected,
   //            [13:10] status_flags, [15:14] zero
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [lfbp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // rsp_tuser: [0] payload_valid
   output logic                                rsp_tuser,
   output logic                                rsp_tlast,
   input  logic                                csr_we,
   input  logic [lfbp_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [lfbp_pkg::BYTE_W-1:0]         csr_wdata
);
   import lfbp_pkg::*;

   // length field wide enough for every accepted length (below MAX_PAYLOAD)
   localparam int unsigned LEN_W = (MAX_PAYLOAD > 2) ? $clog2(MAX_PAYLOAD) : 1;

   logic [BYTE_W-1:0]   start_marker_ff;
   logic [BYTE_W-1:0]   end_marker_ff;

   phase_type           phase_ff,  phase_in;
   logic [LEN_W-1:0]    taken_ff,  taken_in;
   logic [LEN_W-1:0]    length_ff, length_in;
   logic [STATUS_W-1:0] sticky_ff, sticky_in;

   result_type          result_ff, result_in;
   logic                rsp_valid_ff;

   logic                req_fire;
   logic                length_too_big;
   logic [LEN_W:0]      taken_inc;
   logic [BYTE_W-1:0]   rx_byte;

   assign rx_byte    = req_tdata;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   // length byte compared against the limit with one spare bit
   assign length_too_big = {1'b0, rx_byte} >= (BYTE_W + 1)'(MAX_PAYLOAD);
   assign taken_inc      = {1'b0, taken_ff} + (LEN_W + 1)'(1);

   // next parse state and the result of this byte
   always_comb begin
      phase_in  = phase_ff;
      taken_in  = taken_ff;
      length_in = length_ff;
      sticky_in = sticky_ff;
      result_in = '0;
      case (phase_ff)
         PH_WAIT_START: begin
            if (rx_byte == start_marker_ff) begin
               phase_in                 = PH_WAIT_LEN;
               taken_in                 = '0;
               sticky_in[ST_START_SEEN] = 1'b1;
            end
         end
         PH_WAIT_LEN: begin
            if (length_too_big) begin
               // oversized length, keep waiting for a usable one
               result_in.length_rejected = 1'b1;
            end else begin
               length_in               = rx_byte[LEN_W-1:0];
               taken_in                = '0;
               sticky_in[ST_LENGTH_OK] = 1'b1;
               if (rx_byte == '0) begin
                  // empty frame skips straight to the end marker
                  sticky_in[ST_PAYLOAD_DONE] = 1'b1;
                  phase_in                   = PH_WAIT_END;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            result_in.payload_byte  = rx_byte;
            result_in.payload_valid = 1'b1;
            taken_in                = taken_inc[LEN_W-1:0];
            if (taken_inc >= {1'b0, length_ff}) begin
               result_in.payload_last     = 1'b1;
               sticky_in[ST_PAYLOAD_DONE] = 1'b1;
               phase_in                   = PH_WAIT_END;
            end
         end
         default: begin
            if (rx_byte == end_marker_ff) begin
               result_in.frame_done    = 1'b1;
               sticky_in[ST_END_SEEN]  = 1'b1;
               phase_in                = PH_WAIT_START;
            end
         end
      endcase
      result_in.status_flags = sticky_in;
   end

   // marker registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= START_MARKER_RST;
         end_marker_ff   <= END_MARKER_RST;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_START_MARKER: start_marker_ff <= csr_wdata;
            CSR_END_MARKER:   end_marker_ff   <= csr_wdata;
            default:          ;
         endcase
      end
   end

   // parse state, advances only on accepted items
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_WAIT_START;
         taken_ff  <= '0;
         length_ff <= '0;
         sticky_ff <= '0;
      end else if (req_fire) begin
         phase_ff  <= phase_in;
         taken_ff  <= taken_in;
         length_ff <= length_in;
         sticky_ff <= sticky_in;
      end
   end

   // result register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = result_ff.payload_valid;
   assign rsp_tlast  = result_ff.payload_last;
   assign rsp_tdata  = {2'b00, result_ff.status_flags, result_ff.length_rejected,
                        result_ff.frame_done, result_ff.payload_byte};

   // sticky bits never fall outside reset
   property p_sticky_hold;
      @(posedge clock) disable iff (reset)
         !$past(reset) |-> (($past(sticky_ff) & ~sticky_ff) == '0);
   endproperty
   a_sticky_hold: assert property (p_sticky_hold)
      else $error("sticky status bit cleared");

   // a marked last byte must be a payload byte
   property p_last_is_payload;
      @(posedge clock) disable iff (reset)
         rsp_valid_ff && result_ff.payload_last |-> result_ff.payload_valid;
   endproperty
   a_last_is_payload: assert property (p_last_is_payload)
      else $error("last flag without payload byte");

   // payload, close and reject are mutually exclusive per item
   property p_kinds_exclusive;
      @(posedge clock) disable iff (reset)
         rsp_valid_ff |-> $onehot0({result_ff.payload_valid, result_ff.frame_done,
                                    result_ff.length_rejected});
   endproperty
   a_kinds_exclusive: assert property (p_kinds_exclusive)
      else $error("more than one item kind flagged");

   // byte count stays below the stored length while taking payload
   property p_count_bound;
      @(posedge clock) disable iff (reset)
         phase_ff == PH_PAYLOAD |-> taken_ff < length_ff;
   endproperty
   a_count_bound: assert property (p_count_bound)
      else $error("payload count reached length without leaving payload phase");

   // closing a frame leaves the parser hunting for a start byte
   property p_done_returns;
      @(posedge clock) disable iff (reset)
         req_fire && result_in.frame_done |=> phase_ff == PH_WAIT_START;
   endproperty
   a_done_returns: assert property (p_done_returns)
      else $error("frame close did not return to start hunt");

endmodule
